// ===== sv/graph_degree_counter_defines.svh =====
// assertion macros used by the degree counter back end
`ifndef GRAPH_DEGREE_COUNTER_DEFINES_SVH
`define GRAPH_DEGREE_COUNTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define GDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/gdc_pkg.sv =====
package gdc_pkg;

	// field widths and table size
	localparam int VERTEX_W     = 10;
	localparam int MAX_VERTICES = 1 << VERTEX_W;
	localparam int DEGREE_W     = 32;
	localparam int LIMIT_W      = VERTEX_W + 1;
	localparam int MODE_W       = 2;
	localparam int OP_W         = 2;
	localparam int CFG_DATA_W   = LIMIT_W;
	localparam int S_TDATA_W    = 24;
	localparam int M_TDATA_W    = 48;
	localparam int QUEUE_DEPTH  = 2;

	// operation codes carried in tuser
	typedef enum logic [OP_W-1:0] {
		OP_ADD_EDGE = 2'd0,
		OP_QUERY    = 2'd1,
		OP_CLEAR    = 2'd2
	} op_t;

	// degree modes
	typedef enum logic [MODE_W-1:0] {
		MODE_IN         = 2'd0,
		MODE_OUT        = 2'd1,
		MODE_UNDIRECTED = 2'd2
	} mode_t;

	// register indexes
	localparam logic CFG_DEGREE_MODE  = 1'b0;
	localparam logic CFG_VERTEX_COUNT = 1'b1;

	// classified command handed from front to back
	typedef enum logic [1:0] {
		CMD_BUMP  = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [VERTEX_W-1:0]   addr_a;
		logic                  en_a;
		logic [VERTEX_W-1:0]   addr_b;
		logic                  en_b;
	} cmd_t;

	// back-end states
	typedef enum logic [1:0] {
		S_CLEAR = 2'd0,
		S_IDLE  = 2'd1,
		S_BUMP  = 2'd2,
		S_QUERY = 2'd3
	} back_state_t;

	// saturating increment
	function automatic logic [DEGREE_W-1:0] sat_inc(input logic [DEGREE_W-1:0] d);
		sat_inc = (d == {DEGREE_W{1'b1}}) ? d : d + 1'b1;
	endfunction

endpackage

// ===== sv/gdc_ram.sv =====
module gdc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/gdc_front.sv =====
module gdc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [gdc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_xfer,
	input  logic [gdc_pkg::OP_W-1:0]       operation,
	input  logic [gdc_pkg::VERTEX_W-1:0]   source_vertex,
	input  logic [gdc_pkg::VERTEX_W-1:0]   target_vertex,
	output logic                           push,
	output gdc_pkg::cmd_t                  cmd
);

	logic [gdc_pkg::MODE_W-1:0]  degree_mode_q;
	logic [gdc_pkg::LIMIT_W-1:0] vertex_count_q;
	logic [gdc_pkg::LIMIT_W-1:0] limit;
	logic                        src_ok;
	logic                        dst_ok;
	logic                        keep;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_mode_q  <= gdc_pkg::MODE_IN;
			vertex_count_q <= gdc_pkg::LIMIT_W'(gdc_pkg::MAX_VERTICES);
		end else if (cfg_we) begin
			unique case (cfg_index)
				gdc_pkg::CFG_DEGREE_MODE:  degree_mode_q  <= cfg_data[gdc_pkg::MODE_W-1:0];
				gdc_pkg::CFG_VERTEX_COUNT: vertex_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective vertex limit and range checks
	always_comb begin
		limit = (vertex_count_q > gdc_pkg::LIMIT_W'(gdc_pkg::MAX_VERTICES))
			? gdc_pkg::LIMIT_W'(gdc_pkg::MAX_VERTICES) : vertex_count_q;
		src_ok = {1'b0, source_vertex} < limit;
		dst_ok = {1'b0, target_vertex} < limit;
	end

	// classify the item; edges that count nothing and unused codes are dropped
	always_comb begin
		cmd        = '0;
		cmd.kind   = gdc_pkg::CMD_BUMP;
		cmd.addr_a = source_vertex;
		keep       = 1'b0;
		unique case (gdc_pkg::op_t'(operation))
			gdc_pkg::OP_ADD_EDGE: begin
				cmd.kind = gdc_pkg::CMD_BUMP;
				case (gdc_pkg::mode_t'(degree_mode_q))
					gdc_pkg::MODE_IN: begin
						cmd.addr_a = target_vertex;
						cmd.en_a   = dst_ok;
					end
					gdc_pkg::MODE_OUT: begin
						cmd.en_a = src_ok;
					end
					gdc_pkg::MODE_UNDIRECTED: begin
						// second endpoint only when distinct; lone one moves to slot a
						if (src_ok) begin
							cmd.en_a   = 1'b1;
							cmd.addr_b = target_vertex;
							cmd.en_b   = dst_ok && (target_vertex != source_vertex);
						end else begin
							cmd.addr_a = target_vertex;
							cmd.en_a   = dst_ok;
						end
					end
					default: cmd.en_a = 1'b0;
				endcase
				keep = cmd.en_a;
			end
			gdc_pkg::OP_QUERY: begin
				cmd.kind = gdc_pkg::CMD_QUERY;
				cmd.en_a = src_ok;
				keep     = 1'b1;
			end
			gdc_pkg::OP_CLEAR: begin
				cmd.kind = gdc_pkg::CMD_CLEAR;
				keep     = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign push = in_xfer && keep;

endmodule

// ===== sv/gdc_queue.sv =====
module gdc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gdc_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output gdc_pkg::cmd_t pop_cmd
);

	localparam int PTR_W = $clog2(gdc_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(gdc_pkg::QUEUE_DEPTH + 1);

	gdc_pkg::cmd_t    slot_q [gdc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = count_q == CNT_W'(gdc_pkg::QUEUE_DEPTH);
	assign valid   = count_q != '0;
	assign pop_cmd = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			case ({push, pop})
				2'b10:   count_q <= CNT_W'(count_q + 1'b1);
				2'b01:   count_q <= CNT_W'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/gdc_back.sv =====
`include "graph_degree_counter_defines.svh"

module gdc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  gdc_pkg::cmd_t                q_cmd,
	output logic                         pop,
	output logic                         init_busy,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [gdc_pkg::VERTEX_W-1:0] out_vertex,
	output logic [gdc_pkg::DEGREE_W-1:0] out_degree
);

	localparam int AW = gdc_pkg::VERTEX_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(gdc_pkg::MAX_VERTICES - 1);

	gdc_pkg::back_state_t state_q, state_d;
	logic [AW-1:0]                sweep_q, sweep_d;
	logic                         init_q;
	logic [AW-1:0]                cur_q, cur_d;
	logic                         second_q, second_d;
	logic [AW-1:0]                second_addr_q, second_addr_d;
	logic                         out_valid_q;
	logic [AW-1:0]                out_vertex_q;
	logic [gdc_pkg::DEGREE_W-1:0] out_degree_q;

	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [gdc_pkg::DEGREE_W-1:0] ram_wdata;
	logic                         ram_re;
	logic [AW-1:0]                ram_raddr;
	logic [gdc_pkg::DEGREE_W-1:0] ram_rdata;

	logic                         load;
	logic [AW-1:0]                load_vertex;
	logic [gdc_pkg::DEGREE_W-1:0] load_degree;

	// degree table
	gdc_ram #(
		.WIDTH(gdc_pkg::DEGREE_W),
		.DEPTH(gdc_pkg::MAX_VERTICES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// state register and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gdc_pkg::S_CLEAR;
			sweep_q     <= '0;
			init_q      <= 1'b1;
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			sweep_q  <= sweep_d;
			second_q <= second_d;
			if (state_q == gdc_pkg::S_CLEAR && sweep_q == LAST_ADDR) begin
				init_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// address and result payload
	always_ff @(posedge clk) begin
		cur_q         <= cur_d;
		second_addr_q <= second_addr_d;
		if (load) begin
			out_vertex_q <= load_vertex;
			out_degree_q <= load_degree;
		end
	end

	// next state, table access and result load
	always_comb begin
		state_d       = state_q;
		sweep_d       = sweep_q;
		cur_d         = cur_q;
		second_d      = second_q;
		second_addr_d = second_addr_q;
		ram_we        = 1'b0;
		ram_waddr     = cur_q;
		ram_wdata     = '0;
		ram_re        = 1'b0;
		ram_raddr     = q_cmd.addr_a;
		pop           = 1'b0;
		load          = 1'b0;
		load_vertex   = cur_q;
		load_degree   = ram_rdata;
		unique case (state_q)
			gdc_pkg::S_CLEAR: begin
				// zero one entry per cycle
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
				sweep_d   = AW'(sweep_q + 1'b1);
				if (sweep_q == LAST_ADDR) begin
					state_d = gdc_pkg::S_IDLE;
				end
			end
			gdc_pkg::S_IDLE: begin
				if (q_valid && (q_cmd.kind != gdc_pkg::CMD_QUERY || !out_valid_q)) begin
					pop = 1'b1;
					case (q_cmd.kind)
						gdc_pkg::CMD_BUMP: begin
							ram_re        = 1'b1;
							cur_d         = q_cmd.addr_a;
							second_d      = q_cmd.en_b;
							second_addr_d = q_cmd.addr_b;
							state_d       = gdc_pkg::S_BUMP;
						end
						gdc_pkg::CMD_QUERY: begin
							cur_d = q_cmd.addr_a;
							if (q_cmd.en_a) begin
								ram_re  = 1'b1;
								state_d = gdc_pkg::S_QUERY;
							end else begin
								// vertex out of range reads as zero
								load        = 1'b1;
								load_vertex = q_cmd.addr_a;
								load_degree = '0;
							end
						end
						gdc_pkg::CMD_CLEAR: begin
							sweep_d = '0;
							state_d = gdc_pkg::S_CLEAR;
						end
						default: state_d = gdc_pkg::S_IDLE;
					endcase
				end
			end
			gdc_pkg::S_BUMP: begin
				// write back the count, start the second endpoint if any
				ram_we    = 1'b1;
				ram_wdata = gdc_pkg::sat_inc(ram_rdata);
				if (second_q) begin
					ram_re    = 1'b1;
					ram_raddr = second_addr_q;
					cur_d     = second_addr_q;
					second_d  = 1'b0;
				end else begin
					state_d = gdc_pkg::S_IDLE;
				end
			end
			gdc_pkg::S_QUERY: begin
				load    = 1'b1;
				state_d = gdc_pkg::S_IDLE;
			end
			default: state_d = gdc_pkg::S_IDLE;
		endcase
	end

	assign init_busy  = init_q;
	assign out_valid  = out_valid_q;
	assign out_vertex = out_vertex_q;
	assign out_degree = out_degree_q;

	`GDC_ASSERT_NOW(a_pop_nonempty, clk, arst_n, pop, q_valid, "pop from empty queue")
	`GDC_ASSERT_NOW(a_no_overwrite, clk, arst_n, load, !out_valid_q, "result overwritten")
	`GDC_ASSERT_NOW(a_rw_distinct, clk, arst_n, ram_we && ram_re, ram_waddr != ram_raddr, "read and write collide")
	`GDC_ASSERT_NEXT(a_clear_start, clk, arst_n, pop && q_cmd.kind == gdc_pkg::CMD_CLEAR, state_q == gdc_pkg::S_CLEAR && sweep_q == '0, "clear sweep not started")

endmodule

// ===== sv/graph_degree_counter.sv =====
// edge, query and clear items each take one transfer slot; the queue holds two commands
// edge: the back end reads the count on pop and writes it back saturated in S_BUMP, again for a second endpoint
// query: result loaded from the table read in S_QUERY, or as zero at pop if out of range; waits while one is pending
// clear: after the cycle that pops it, a table sweep zeroes all 1024 entries, one entry per cycle
// reset: async, active low; a sweep zeroes all 1024 table entries, s_tready low meanwhile
// configuration writes are taken during the sweep
module graph_degree_counter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [gdc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// source_vertex [9:0], target_vertex [19:10], zero fill
	input  logic [gdc_pkg::S_TDATA_W-1:0]   s_tdata,
	// operation [1:0]
	input  logic [gdc_pkg::OP_W-1:0]        s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// vertex [9:0], degree [41:10], zero fill
	output logic [gdc_pkg::M_TDATA_W-1:0]   m_tdata
);

	localparam int VW = gdc_pkg::VERTEX_W;
	localparam int DW = gdc_pkg::DEGREE_W;

	logic          in_xfer;
	logic          push;
	gdc_pkg::cmd_t push_cmd;
	logic          q_full;
	logic          q_valid;
	logic          pop;
	gdc_pkg::cmd_t pop_cmd;
	logic          init_busy;
	logic [VW-1:0] out_vertex;
	logic [DW-1:0] out_degree;

	assign s_tready = !q_full && !init_busy;
	assign in_xfer  = s_tvalid && s_tready;

	// classify items and hold registers
	gdc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_xfer      (in_xfer),
		.operation    (s_tuser),
		.source_vertex(s_tdata[VW-1:0]),
		.target_vertex(s_tdata[2*VW-1:VW]),
		.push         (push),
		.cmd          (push_cmd)
	);

	// command queue between front and back
	gdc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (pop),
		.valid   (q_valid),
		.pop_cmd (pop_cmd)
	);

	// table update and query
	gdc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (pop_cmd),
		.pop       (pop),
		.init_busy (init_busy),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_vertex(out_vertex),
		.out_degree(out_degree)
	);

	assign m_tdata = {{(gdc_pkg::M_TDATA_W - VW - DW){1'b0}}, out_degree, out_vertex};

endmodule

// ===== dv/graph_degree_counter_tb.sv =====
`timescale 1ns / 1ps

module graph_degree_counter_tb;
	import gdc_pkg::*;

	// codes the package leaves unnamed
	localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam int RANDOM_PHASES  = 10;
	localparam int ITEMS_PER_PHASE = 180;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int SETTLE_CYCLES  = 16;

	typedef struct {
		logic [OP_W-1:0]     op;
		logic [VERTEX_W-1:0] src;
		logic [VERTEX_W-1:0] dst;
	} stream_item_t;

	typedef struct {
		logic [VERTEX_W-1:0] vertex;
		logic [DEGREE_W-1:0] degree;
	} degree_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [OP_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b1;
	logic [M_TDATA_W-1:0] m_tdata;

	// mirror of the counter table and registers
	logic [DEGREE_W-1:0] degree_mirror [MAX_VERTICES];
	logic [MODE_W-1:0] mode_shadow = MODE_IN;
	logic [LIMIT_W-1:0] count_shadow = 11'd1024;

	stream_item_t items_to_send[$];
	degree_report_t reports_due[$];
	stream_item_t offered;

	int fail_count = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	int rx_hold = 0;
	int hold_req = 0;
	int hold_done = 0;
	logic send_hold = 1'b0;
	logic tx_idle_on = 1'b0;
	logic rx_idle_on = 1'b0;

	graph_degree_counter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int active_limit();
		return (count_shadow > MAX_VERTICES) ? MAX_VERTICES : int'(count_shadow);
	endfunction

	function automatic void count_endpoint(input logic [VERTEX_W-1:0] v);
		if (v < active_limit() && degree_mirror[v] != {DEGREE_W{1'b1}})
			degree_mirror[v] = degree_mirror[v] + 1'b1;
	endfunction

	// update the mirror for one accepted item, queue a report for a query
	function automatic void predict_degrees(input stream_item_t it);
		degree_report_t rep;
		case (it.op)
			OP_ADD_EDGE: begin
				case (mode_shadow)
					MODE_IN: count_endpoint(it.dst);
					MODE_OUT: count_endpoint(it.src);
					MODE_UNDIRECTED: begin
						count_endpoint(it.src);
						if (it.dst != it.src)
							count_endpoint(it.dst);
					end
					default: ;
				endcase
			end
			OP_QUERY: begin
				rep.vertex = it.src;
				rep.degree = (it.src < active_limit()) ? degree_mirror[it.src] : '0;
				reports_due.push_back(rep);
			end
			OP_CLEAR: begin
				foreach (degree_mirror[i])
					degree_mirror[i] = '0;
			end
			default: ;
		endcase
	endfunction

	// vertex picks lean on a few hot vertices and the edge of the range
	function automatic logic [VERTEX_W-1:0] pick_vertex(input int lim);
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 45)
			v = $urandom_range(0, 7);
		else if (r < 65)
			v = lim - 2 + int'($urandom_range(0, 3));
		else if (r < 85)
			v = $urandom_range(0, MAX_VERTICES - 1);
		else
			v = (lim > 0) ? int'($urandom_range(0, lim - 1)) : 0;
		if (v < 0) v = 0;
		if (v > MAX_VERTICES - 1) v = MAX_VERTICES - 1;
		return v[VERTEX_W-1:0];
	endfunction

	function automatic stream_item_t random_item();
		stream_item_t it;
		int r;
		r = $urandom_range(0, 99);
		it.op = (r < 60) ? OP_ADD_EDGE : (r < 94) ? OP_QUERY : (r < 95) ? OP_CLEAR : OP_UNUSED;
		it.src = pick_vertex(active_limit());
		it.dst = ($urandom_range(0, 9) == 0) ? it.src : pick_vertex(active_limit());
		return it;
	endfunction

	task automatic queue_item(input logic [OP_W-1:0] op, input int src, input int dst);
		stream_item_t it;
		it.op = op;
		it.src = src[VERTEX_W-1:0];
		it.dst = dst[VERTEX_W-1:0];
		items_to_send.push_back(it);
	endtask

	// both registers, written after wait_idle, or during the reset sweep for the first call
	task automatic apply_settings(input logic [MODE_W-1:0] mode, input int count);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_DEGREE_MODE;
		cfg_data <= {{(CFG_DATA_W-MODE_W){1'b0}}, mode};
		mode_shadow = mode;
		@(posedge clk);
		cfg_index <= CFG_VERTEX_COUNT;
		cfg_data <= count[CFG_DATA_W-1:0];
		count_shadow = count[LIMIT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold the sender until everything sent has been reported, then settle
	task automatic wait_idle();
		@(negedge clk);
		while (items_to_send.size() != 0 || s_tvalid || reports_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sender: offers items from the queue with random gaps
	always @(posedge clk) begin
		stream_item_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_degrees(offered);
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
					s_tvalid <= 1'b0;
				end else if (send_hold || items_to_send.size() == 0) begin
					s_tvalid <= 1'b0;
				end else begin
					nxt = items_to_send.pop_front();
					offered <= nxt;
					s_tvalid <= 1'b1;
					s_tdata <= {{(S_TDATA_W-2*VERTEX_W){1'b0}}, nxt.dst, nxt.src};
					s_tuser <= nxt.op;
					tx_gap <= tx_idle_on ? pick_gap() : 0;
				end
			end
		end
	end

	// receiver: checks each result transfer and drives m_tready
	always @(posedge clk) begin
		degree_report_t want;
		int g;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (reports_due.size() == 0) begin
					$error("unexpected result: vertex %0d degree %0d",
						m_tdata[VERTEX_W-1:0], m_tdata[VERTEX_W +: DEGREE_W]);
					fail_count++;
				end else begin
					want = reports_due.pop_front();
					if (m_tdata[VERTEX_W-1:0] !== want.vertex) begin
						$error("vertex mismatch: expected %0d, actual %0d",
							want.vertex, m_tdata[VERTEX_W-1:0]);
						fail_count++;
					end
					if (m_tdata[VERTEX_W +: DEGREE_W] !== want.degree) begin
						$error("degree mismatch: expected %0d, actual %0d",
							want.degree, m_tdata[VERTEX_W +: DEGREE_W]);
						fail_count++;
					end
				end
			end
			if (rx_hold > 0) begin
				rx_hold <= rx_hold - 1;
				m_tready <= 1'b0;
			end else if (hold_req != hold_done) begin
				hold_done <= hold_done + 1;
				rx_hold <= HOLDOFF_CYCLES;
				m_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				m_tready <= 1'b0;
			end else if (m_tvalid && m_tready && rx_idle_on) begin
				g = pick_gap();
				rx_gap <= (g > 0) ? g - 1 : 0;
				m_tready <= (g == 0);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// stimulus
	initial begin
		logic [MODE_W-1:0] mode_plan [7];
		int count_plan [7];
		int sent;
		stream_item_t it;
		mode_plan = '{MODE_OUT, MODE_UNDIRECTED, MODE_UNDIRECTED, MODE_IN, MODE_UNUSED,
			MODE_OUT, MODE_IN};
		count_plan = '{1, 37, 1024, 0, 2047, 1023, 1024};
		foreach (degree_mirror[i])
			degree_mirror[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: undirected counting with part of the range cut off
		apply_settings(MODE_UNDIRECTED, 1000);
		queue_item(OP_ADD_EDGE, 0, 1023);
		queue_item(OP_ADD_EDGE, 5, 5);
		queue_item(OP_ADD_EDGE, 999, 0);
		queue_item(OP_ADD_EDGE, 1023, 1023);
		queue_item(OP_ADD_EDGE, 1000, 999);
		queue_item(OP_QUERY, 0, 1023);
		queue_item(OP_QUERY, 5, 0);
		queue_item(OP_QUERY, 999, 682);
		queue_item(OP_QUERY, 1023, 341);
		queue_item(OP_QUERY, 1000, 0);
		queue_item(OP_UNUSED, 0, 0);
		queue_item(OP_UNUSED, 1023, 1023);
		queue_item(OP_QUERY, 0, 0);
		queue_item(OP_CLEAR, 682, 341);
		queue_item(OP_QUERY, 0, 0);
		queue_item(OP_QUERY, 999, 0);
		queue_item(OP_ADD_EDGE, 682, 341);
		queue_item(OP_ADD_EDGE, 341, 682);
		queue_item(OP_QUERY, 682, 1023);
		queue_item(OP_QUERY, 341, 0);
		wait_idle();

		// random phases over a spread of register settings
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph < 7)
				apply_settings(mode_plan[ph], count_plan[ph]);
			else
				apply_settings(MODE_W'($urandom_range(0, 3)), int'($urandom_range(0, 2047)));
			tx_idle_on <= (ph == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
			rx_idle_on <= (ph == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);

			// long receiver hold-off while queries keep coming
			if (ph == 2) begin
				@(posedge clk);
				hold_req <= hold_req + 1;
				for (int i = 0; i < 40; i++)
					queue_item(OP_QUERY, pick_vertex(active_limit()), $urandom_range(0, 1023));
				wait_idle();
			end

			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				it = random_item();
				items_to_send.push_back(it);
				if (it.op != OP_UNUSED)
					sent++;
				// sender pause midway through one phase
				if (ph == 4 && sent == ITEMS_PER_PHASE / 2 && it.op != OP_UNUSED) begin
					@(negedge clk);
					while (items_to_send.size() != 0 || s_tvalid)
						@(negedge clk);
					@(posedge clk);
					send_hold <= 1'b1;
					@(negedge clk);
					while (reports_due.size() != 0)
						@(negedge clk);
					@(posedge clk);
					send_hold <= 1'b0;
				end
			end
			// closing query: its report means every earlier item is done
			queue_item(OP_QUERY, pick_vertex(active_limit()), $urandom_range(0, 1023));
			wait_idle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/gdc_pkg.sv
sv/gdc_ram.sv
sv/gdc_front.sv
sv/gdc_queue.sv
sv/gdc_back.sv
sv/graph_degree_counter.sv
dv/graph_degree_counter_tb.sv
